@@ design/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

   localparam int QueueDepth = 4;
   localparam int MaxBytes = 4;

   typedef enum logic [2:0] {
      StData     = 3'd0,
      StDone     = 3'd1,
      StNoQuote  = 3'd2,
      StBadEsc   = 3'd3,
      StBadHex   = 3'd4,
      StBadSur   = 3'd5
   } status_type;

   // One queued word: all results caused by one input byte.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] data;
      logic [1:0]               last_idx;
      status_type               status;
      logic [15:0]              length;
   } cmd_type;

endpackage
`default_nettype wire

@@ design/jsu_if.sv @@
// Valid/ready channel interfaces for input bytes and result words.
`default_nettype none
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       start_req;

   modport source (output valid, output text_byte, output start_req, input ready);
   modport sink (input valid, input text_byte, input start_req, output ready);
endinterface

interface jsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [2:0]  status;
   logic [15:0] decoded_length;
   logic        last;

   modport source (output valid, output out_byte, output status, output decoded_length,
                   output last, input ready);
   modport sink (input valid, input out_byte, input status, input decoded_length,
                 input last, output ready);
endinterface
`default_nettype wire

@@ design/jsu_front.sv @@
// Front end: parses escapes, builds UTF-8 bytes and queues at most one word per input byte.
`default_nettype none
module jsu_front (
   input  wire               clock,
   input  wire               reset,
   jsu_req_if.sink           req,
   input  wire               q_full,
   output logic              push,
   output jsu_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      PhIdle   = 7'b0000001,
      PhText   = 7'b0000010,
      PhEsc    = 7'b0000100,
      PhHex1   = 7'b0001000,
      PhWantBs = 7'b0010000,
      PhWantU  = 7'b0100000,
      PhHex2   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
   } enc_type;

   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChBack  = 8'h5C;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChNul   = 8'h00;
   localparam logic [7:0] ChB     = 8'h62;
   localparam logic [7:0] ChF     = 8'h66;
   localparam logic [7:0] ChN     = 8'h6E;
   localparam logic [7:0] ChR     = 8'h72;
   localparam logic [7:0] ChT     = 8'h74;
   localparam logic [7:0] ChU     = 8'h75;

   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'h10;
      if (ch >= 8'h30 && ch <= 8'h39) r = {1'b0, ch[3:0]};
      else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
         r = {1'b0, ch[3:0] + 4'd9};
      return r;
   endfunction

   function automatic enc_type encode(input logic [20:0] u);
      enc_type e;
      e = '0;
      if (u <= 21'h00007F) begin
         e.data[0] = u[7:0];
         e.last_idx = 2'd0;
      end else if (u <= 21'h0007FF) begin
         e.data[0] = 8'hC0 | {3'b0, u[10:6]};
         e.data[1] = 8'h80 | {2'b0, u[5:0]};
         e.last_idx = 2'd1;
      end else if (u <= 21'h00FFFF) begin
         e.data[0] = 8'hE0 | {4'b0, u[15:12]};
         e.data[1] = 8'h80 | {2'b0, u[11:6]};
         e.data[2] = 8'h80 | {2'b0, u[5:0]};
         e.last_idx = 2'd2;
      end else begin
         e.data[0] = 8'hF0 | {5'b0, u[20:18]};
         e.data[1] = 8'h80 | {2'b0, u[17:12]};
         e.data[2] = 8'h80 | {2'b0, u[11:6]};
         e.data[3] = 8'h80 | {2'b0, u[5:0]};
         e.last_idx = 2'd3;
      end
      return e;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic [9:0]  high_half_ff, high_half_in;
   logic [15:0] byte_count_ff, byte_count_in;

   logic        accept;
   logic [7:0]  ch;
   logic [4:0]  digit;
   logic [15:0] accum_next;
   logic [20:0] pair_cp;
   logic        data_out;
   logic [16:0] count_sum;
   enc_type     enc;

   assign req.ready = !q_full;
   assign accept = req.valid && req.ready;
   assign ch = req.text_byte;
   assign digit = hex_digit(ch);
   assign accum_next = {hex_accum_ff[11:0], digit[3:0]};
   assign pair_cp = 21'h010000 + {1'b0, high_half_ff, accum_next[9:0]};

   always_comb begin
      phase_in = phase_ff;
      hex_count_in = hex_count_ff;
      hex_accum_in = hex_accum_ff;
      high_half_in = high_half_ff;
      byte_count_in = byte_count_ff;
      push = 1'b0;
      data_out = 1'b0;
      count_sum = '0;
      cmd = '0;
      cmd.status = jsu_pkg::StData;
      // A plain text byte passes through as one byte, whatever its value.
      enc = '0;
      enc.data[0] = ch;
      if (req.start_req) begin
         phase_in = PhText;
         hex_count_in = '0;
         hex_accum_in = '0;
         high_half_in = '0;
         byte_count_in = '0;
      end else begin
         unique case (phase_ff)
            PhIdle: begin
            end
            PhText: begin
               if (ch == ChQuote) begin
                  phase_in = PhIdle;
                  push = 1'b1;
                  cmd.status = jsu_pkg::StDone;
                  cmd.length = byte_count_ff;
               end else if (ch == ChBack) begin
                  phase_in = PhEsc;
               end else if (ch == ChNul) begin
                  phase_in = PhIdle;
                  push = 1'b1;
                  cmd.status = jsu_pkg::StNoQuote;
               end else begin
                  data_out = 1'b1;
               end
            end
            PhEsc: begin
               phase_in = PhText;
               data_out = 1'b1;
               unique case (ch)
                  ChQuote, ChBack, ChSlash: enc = encode({13'b0, ch});
                  ChB: enc = encode(21'h08);
                  ChF: enc = encode(21'h0C);
                  ChN: enc = encode(21'h0A);
                  ChR: enc = encode(21'h0D);
                  ChT: enc = encode(21'h09);
                  ChU: begin
                     data_out = 1'b0;
                     phase_in = PhHex1;
                     hex_count_in = '0;
                     hex_accum_in = '0;
                  end
                  default: begin
                     data_out = 1'b0;
                     phase_in = PhIdle;
                     push = 1'b1;
                     cmd.status = jsu_pkg::StBadEsc;
                  end
               endcase
            end
            PhHex1, PhHex2: begin
               if (digit[4]) begin
                  phase_in = PhIdle;
                  push = 1'b1;
                  cmd.status = jsu_pkg::StBadHex;
               end else begin
                  hex_accum_in = accum_next;
                  if (hex_count_ff != 2'd3) begin
                     hex_count_in = hex_count_ff + 2'd1;
                  end else begin
                     hex_count_in = '0;
                     if (phase_ff == PhHex1) begin
                        if (accum_next >= 16'hD800 && accum_next <= 16'hDBFF) begin
                           high_half_in = accum_next[9:0];
                           phase_in = PhWantBs;
                        end else begin
                           phase_in = PhText;
                           data_out = 1'b1;
                           enc = encode({5'b0, accum_next});
                        end
                     end else if (accum_next < 16'hDC00 || accum_next > 16'hDFFF) begin
                        phase_in = PhIdle;
                        push = 1'b1;
                        cmd.status = jsu_pkg::StBadSur;
                     end else begin
                        phase_in = PhText;
                        data_out = 1'b1;
                        enc = encode(pair_cp);
                     end
                  end
               end
            end
            PhWantBs: begin
               if (ch != ChBack) begin
                  phase_in = PhIdle;
                  push = 1'b1;
                  cmd.status = jsu_pkg::StBadSur;
               end else begin
                  phase_in = PhWantU;
               end
            end
            PhWantU: begin
               if (ch != ChU) begin
                  phase_in = PhIdle;
                  push = 1'b1;
                  cmd.status = jsu_pkg::StBadSur;
               end else begin
                  phase_in = PhHex2;
                  hex_count_in = '0;
                  hex_accum_in = '0;
               end
            end
            default: phase_in = PhIdle;
         endcase
         if (data_out) begin
            push = 1'b1;
            cmd.data = enc.data;
            cmd.last_idx = enc.last_idx;
            count_sum = {1'b0, byte_count_ff} + {15'b0, enc.last_idx} + 17'd1;
            byte_count_in = count_sum[16] ? 16'hFFFF : count_sum[15:0];
         end
      end
      push = push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         hex_count_ff <= '0;
         hex_accum_ff <= '0;
         high_half_ff <= '0;
         byte_count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_count_ff <= hex_count_in;
         hex_accum_ff <= hex_accum_in;
         high_half_ff <= high_half_in;
         byte_count_ff <= byte_count_in;
      end
   end

endmodule
`default_nettype wire

@@ design/jsu_queue.sv @@
// Small queue of result words between the front end and the output sequencer.
`default_nettype none
module jsu_queue #(
   parameter int Depth = jsu_pkg::QueueDepth
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  jsu_pkg::cmd_type  push_cmd,
   input  wire               pop,
   output jsu_pkg::cmd_type  head_cmd,
   output logic              full,
   output logic              not_empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   jsu_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign full = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CntW'(1);
      else if (pop && !push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop) rd_ptr_ff <= next_ptr(rd_ptr_ff);
         count_ff <= count_in;
      end
   end

   no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue read while empty");
   count_tracks_ops: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue count lost a write");

endmodule
`default_nettype wire

@@ design/jsu_back.sv @@
// Output sequencer: sends the one to four results of each queued word in order.
`default_nettype none
module jsu_back (
   input  wire               clock,
   input  wire               reset,
   input  jsu_pkg::cmd_type  head_cmd,
   input  wire               q_not_empty,
   output logic              pop,
   jsu_rsp_if.source         rsp
);

   jsu_pkg::cmd_type cur_ff;
   logic             cur_valid_ff;
   logic [1:0]       idx_ff;
   logic             at_last;
   logic             taken;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign taken = rsp.valid && rsp.ready;
   assign pop = q_not_empty && (!cur_valid_ff || (taken && at_last));

   assign rsp.valid = cur_valid_ff;
   assign rsp.out_byte = cur_ff.data[idx_ff];
   assign rsp.status = cur_ff.status;
   assign rsp.decoded_length = cur_ff.length;
   assign rsp.last = at_last;

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else if (pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff <= '0;
      end else if (taken) begin
         if (at_last) begin
            cur_valid_ff <= 1'b0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   status_data_only_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != jsu_pkg::StData) |-> (rsp.last && rsp.out_byte == 8'h00))
      else $error("status word carries data bytes");
   idx_within_word: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (idx_ff <= cur_ff.last_idx))
      else $error("byte index past end of word");
   advance_after_take: assert property (@(posedge clock) disable iff (reset)
      (taken && !at_last) |=> (rsp.valid && idx_ff == $past(idx_ff) + 2'd1))
      else $error("multi-byte word did not advance");

endmodule
`default_nettype wire

@@ design/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
// With an idle output, a byte's first result goes through the queue and the output register.
// Throughput: one input byte and one result per cycle while the receiver is ready; a \u escape
// that encodes to two to four UTF-8 bytes holds the output, and the Depth-word queue between
// the parser and the output sequencer absorbs the difference; the input stalls while it is full.
// Reset (synchronous): parser returns to idle, counters clear, the queue empties.
`default_nettype none
module json_string_unescape_utf8 #(
   parameter int Depth = jsu_pkg::QueueDepth
) (
   input  wire        clock,
   input  wire        reset,
   jsu_req_if.sink    req,
   jsu_rsp_if.source  rsp
);

   logic             push;
   logic             pop;
   logic             q_full;
   logic             q_not_empty;
   jsu_pkg::cmd_type push_cmd;
   jsu_pkg::cmd_type head_cmd;

   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .push   (push),
      .cmd    (push_cmd)
   );

   jsu_queue #(.Depth(Depth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .q_not_empty (q_not_empty),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb;

   localparam int Limit = 100000;
   localparam int HoldCycles = 150;
   localparam int RandomItems = 205;

   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChLowU = 8'h75;

   localparam logic [7:0] EscChars [8] = '{ChQuote, ChBslash, ChSlash, 8'h62, 8'h66, 8'h6E,
                                           8'h72, 8'h74};
   localparam logic [15:0] UnitEdges [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                             16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

   typedef enum logic [2:0] {
      PhIdle, PhText, PhEsc, PhHex1, PhWantBs, PhWantU, PhHex2
   } scan_phase_type;

   typedef enum logic [1:0] {
      RowModel, RowNone, RowWord
   } row_kind_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      jsu_pkg::status_type  status;
      logic [15:0]          length;
      logic                 last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]   text;
      logic         start;
      row_kind_type kind;
      rsp_word_type word;
   } dir_row_type;

   localparam rsp_word_type NoWord = '0;

   localparam dir_row_type DirectedRows [28] = '{
      '{8'h41,    1'b0, RowNone,  NoWord},
      '{ChQuote,  1'b1, RowNone,  NoWord},
      '{8'hFF,    1'b0, RowWord,  '{8'hFF, jsu_pkg::StData, 16'd0, 1'b1}},
      '{ChBslash, 1'b0, RowModel, NoWord},
      '{ChLowU,   1'b0, RowModel, NoWord},
      '{8'h44,    1'b0, RowModel, NoWord},
      '{8'h43,    1'b0, RowModel, NoWord},
      '{8'h30,    1'b0, RowModel, NoWord},
      '{8'h30,    1'b0, RowModel, NoWord},
      '{ChBslash, 1'b0, RowModel, NoWord},
      '{ChLowU,   1'b0, RowModel, NoWord},
      '{8'h64,    1'b0, RowModel, NoWord},
      '{8'h38,    1'b0, RowModel, NoWord},
      '{8'h30,    1'b0, RowModel, NoWord},
      '{8'h30,    1'b0, RowModel, NoWord},
      '{8'h78,    1'b0, RowWord,  '{8'h00, jsu_pkg::StBadSur, 16'd0, 1'b1}},
      '{ChQuote,  1'b1, RowNone,  NoWord},
      '{ChQuote,  1'b1, RowNone,  NoWord},
      '{8'h00,    1'b0, RowWord,  '{8'h00, jsu_pkg::StNoQuote, 16'd0, 1'b1}},
      '{ChQuote,  1'b1, RowNone,  NoWord},
      '{ChBslash, 1'b0, RowNone,  NoWord},
      '{8'h00,    1'b0, RowWord,  '{8'h00, jsu_pkg::StBadEsc, 16'd0, 1'b1}},
      '{ChQuote,  1'b1, RowNone,  NoWord},
      '{ChBslash, 1'b0, RowNone,  NoWord},
      '{ChLowU,   1'b0, RowNone,  NoWord},
      '{8'h00,    1'b0, RowWord,  '{8'h00, jsu_pkg::StBadHex, 16'd0, 1'b1}},
      '{ChQuote,  1'b1, RowNone,  NoWord},
      '{ChQuote,  1'b0, RowWord,  '{8'h00, jsu_pkg::StDone, 16'd0, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape_utf8 dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always #5 clock = ~clock;

   scan_phase_type scan_phase = PhIdle;
   logic [1:0] nib_count = '0;
   logic [15:0] nib_accum = '0;
   logic [9:0] high_bits = '0;
   logic [15:0] out_count = '0;

   rsp_word_type step_words [$];
   rsp_word_type decoded_due [$];

   int mismatches = 0;
   int live_count = 0;
   int unsigned cycle_count = 0;
   logic hold_request = 1'b0;
   logic hold_served = 1'b0;

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   task automatic put_word(input logic [7:0] b, input jsu_pkg::status_type st,
                           input logic [15:0] len);
      rsp_word_type w;
      w.out_byte = b;
      w.status = st;
      w.length = len;
      w.last = 1'b0;
      step_words = {step_words, w};
   endtask

   task automatic put_data(input logic [7:0] b);
      if (out_count != 16'hFFFF) out_count++;
      put_word(b, jsu_pkg::StData, 16'd0);
   endtask

   task automatic end_error(input jsu_pkg::status_type st);
      scan_phase = PhIdle;
      put_word(8'h00, st, 16'd0);
   endtask

   task automatic put_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         put_data(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         put_data({3'b110, cp[10:6]});
         put_data({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
         put_data({4'b1110, cp[15:12]});
         put_data({2'b10, cp[11:6]});
         put_data({2'b10, cp[5:0]});
      end else begin
         put_data({5'b11110, cp[20:18]});
         put_data({2'b10, cp[17:12]});
         put_data({2'b10, cp[11:6]});
         put_data({2'b10, cp[5:0]});
      end
   endtask

   // Advances the decoder state by one accepted byte and leaves its words in step_words.
   task automatic decode_byte(input logic [7:0] c, input logic s);
      int nib;
      rsp_word_type w;
      step_words.delete();
      if (s) begin
         scan_phase = PhText;
         nib_count = '0;
         nib_accum = '0;
         high_bits = '0;
         out_count = '0;
      end else begin
         case (scan_phase)
            PhText: begin
               if (c == ChQuote) begin
                  scan_phase = PhIdle;
                  put_word(8'h00, jsu_pkg::StDone, out_count);
               end else if (c == ChBslash) begin
                  scan_phase = PhEsc;
               end else if (c == 8'h00) begin
                  end_error(jsu_pkg::StNoQuote);
               end else begin
                  put_data(c);
               end
            end
            PhEsc: begin
               scan_phase = PhText;
               case (c)
                  ChQuote, ChBslash, ChSlash: put_data(c);
                  8'h62: put_data(8'h08);
                  8'h66: put_data(8'h0C);
                  8'h6E: put_data(8'h0A);
                  8'h72: put_data(8'h0D);
                  8'h74: put_data(8'h09);
                  ChLowU: begin
                     scan_phase = PhHex1;
                     nib_count = '0;
                     nib_accum = '0;
                  end
                  default: end_error(jsu_pkg::StBadEsc);
               endcase
            end
            PhHex1, PhHex2: begin
               nib = nibble_of(c);
               if (nib < 0) begin
                  end_error(jsu_pkg::StBadHex);
               end else begin
                  nib_accum = {nib_accum[11:0], nib[3:0]};
                  if (nib_count != 2'd3) begin
                     nib_count++;
                  end else begin
                     nib_count = '0;
                     if (scan_phase == PhHex1) begin
                        if (nib_accum >= 16'hD800 && nib_accum <= 16'hDBFF) begin
                           high_bits = nib_accum[9:0];
                           scan_phase = PhWantBs;
                        end else begin
                           scan_phase = PhText;
                           put_utf8({5'd0, nib_accum});
                        end
                     end else if (nib_accum < 16'hDC00 || nib_accum > 16'hDFFF) begin
                        end_error(jsu_pkg::StBadSur);
                     end else begin
                        scan_phase = PhText;
                        put_utf8(21'h10000 + {1'b0, high_bits, nib_accum[9:0]});
                     end
                  end
               end
            end
            PhWantBs: begin
               if (c != ChBslash) end_error(jsu_pkg::StBadSur);
               else scan_phase = PhWantU;
            end
            PhWantU: begin
               if (c != ChLowU) begin
                  end_error(jsu_pkg::StBadSur);
               end else begin
                  scan_phase = PhHex2;
                  nib_count = '0;
                  nib_accum = '0;
               end
            end
            default: ;
         endcase
      end
      if (step_words.size() > 0) begin
         w = step_words[step_words.size() - 1];
         w.last = 1'b1;
         step_words[step_words.size() - 1] = w;
      end
   endtask

   task automatic sender_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 60) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else if (r < 98) n = $urandom_range(4, 10);
      else n = $urandom_range(20, 40);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [7:0] c, input logic s, input row_kind_type kind,
                            input rsp_word_type w);
      if (s || scan_phase != PhIdle) live_count++;
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= c;
      req_ch.start_req <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decode_byte(c, s);
      case (kind)
         RowModel: decoded_due = {decoded_due, step_words};
         RowWord: decoded_due = {decoded_due, w};
         default: ;
      endcase
      sender_gap();
   endtask

   task automatic send_text(input logic [7:0] c);
      send_word(c, 1'b0, RowModel, NoWord);
   endtask

   task automatic send_start();
      send_word(8'($urandom_range(0, 255)), 1'b1, RowModel, NoWord);
   endtask

   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == ChQuote || c == ChBslash);
      return c;
   endfunction

   function automatic logic [7:0] rand_not(input logic [7:0] x);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == x);
      return c;
   endfunction

   function automatic logic [7:0] rand_bad_escape();
      logic [7:0] c;
      logic hit;
      do begin
         c = 8'($urandom_range(0, 255));
         hit = (c == ChLowU);
         foreach (EscChars[i]) if (c == EscChars[i]) hit = 1'b1;
      end while (hit);
      return c;
   endfunction

   function automatic logic [7:0] rand_bad_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'd0, nib};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
   endfunction

   function automatic logic [9:0] rand_half();
      case ($urandom_range(0, 7))
         0: return 10'h000;
         1: return 10'h3FF;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [15:0] rand_unit();
      logic [15:0] u;
      case ($urandom_range(0, 5))
         0: u = 16'($urandom_range(0, 16'h7F));
         1: u = 16'($urandom_range(16'h80, 16'h7FF));
         2: u = 16'($urandom_range(16'h800, 16'hD7FF));
         3: u = 16'($urandom_range(16'hDC00, 16'hFFFF));
         4: u = UnitEdges[$urandom_range(0, 7)];
         default: u = 16'($urandom);
      endcase
      if (u >= 16'hD800 && u <= 16'hDBFF) u = u ^ 16'h0400;
      return u;
   endfunction

   function automatic logic [15:0] rand_bad_low();
      logic [15:0] u;
      case ($urandom_range(0, 3))
         0: u = 16'hDBFF;
         1: u = 16'hE000;
         default: u = 16'($urandom);
      endcase
      if (u >= 16'hDC00 && u <= 16'hDFFF) u = u ^ 16'h2000;
      return u;
   endfunction

   task automatic send_unit(input logic [15:0] v);
      send_text(ChBslash);
      send_text(ChLowU);
      send_text(hex_char(v[15:12]));
      send_text(hex_char(v[11:8]));
      send_text(hex_char(v[7:4]));
      send_text(hex_char(v[3:0]));
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 6))
         0: send_text(8'h00);
         1: begin
            send_text(ChBslash);
            send_text(rand_bad_escape());
         end
         2: begin
            send_text(ChBslash);
            send_text(ChLowU);
            repeat ($urandom_range(0, 3)) send_text(hex_char(4'($urandom_range(0, 15))));
            send_text(rand_bad_hex());
         end
         3: begin
            send_unit({6'b110110, rand_half()});
            send_text(rand_not(ChBslash));
         end
         4: begin
            send_unit({6'b110110, rand_half()});
            send_text(ChBslash);
            send_text(rand_not(ChLowU));
         end
         5: begin
            send_unit({6'b110110, rand_half()});
            send_unit(rand_bad_low());
         end
         default: send_start();
      endcase
   endtask

   task automatic send_string();
      int n;
      int pick;
      logic ended;
      send_start();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      ended = 1'b0;
      while (n > 0 && !ended) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_text(rand_plain());
         end else if (pick < 55) begin
            send_text(ChBslash);
            send_text(EscChars[$urandom_range(0, 7)]);
         end else if (pick < 75) begin
            send_unit(rand_unit());
         end else if (pick < 95) begin
            send_unit({6'b110110, rand_half()});
            send_unit({6'b110111, rand_half()});
         end else begin
            send_broken();
            ended = 1'b1;
         end
         n--;
      end
      if (!ended && $urandom_range(0, 9) != 0) begin
         send_text(ChQuote);
         ended = 1'b1;
      end
      if (ended && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) send_text(8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int base;
      logic drained;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.text_byte = 8'h00;
      req_ch.start_req = 1'b0;
      drained = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i])
         send_word(DirectedRows[i].text, DirectedRows[i].start, DirectedRows[i].kind,
                   DirectedRows[i].word);

      base = live_count;
      while (live_count - base < RandomItems) begin
         if (live_count - base > 60) hold_request = 1'b1;
         if (!drained && live_count - base > 130) begin
            drained = 1'b1;
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (decoded_due.size() != 0);
         end
         send_string();
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (decoded_due.size() != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin : rsp_pacing
      int r;
      int n;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !hold_served) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_served = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) n = $urandom_range(1, 20);
            else if (r < 88) n = $urandom_range(1, 3);
            else if (r < 98) n = $urandom_range(4, 12);
            else n = $urandom_range(20, 60);
            rsp_ch.ready <= (r < 50);
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_word_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decoded_due.size() == 0) begin
            $display("%0t: word with nothing expected, expected none, actual %h/%0d/%0d/%b",
                     $time, rsp_ch.out_byte, rsp_ch.status, rsp_ch.decoded_length,
                     rsp_ch.last);
            mismatches++;
         end else begin
            w = decoded_due.pop_front();
            check_field("out_byte", 16'(w.out_byte), 16'(rsp_ch.out_byte));
            check_field("status", 16'(w.status), 16'(rsp_ch.status));
            check_field("decoded_length", w.length, rsp_ch.decoded_length);
            check_field("last", 16'(w.last), 16'(rsp_ch.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= Limit) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
